[sv/evaluation_score_text_parser_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the score text parser
// Concurrent checks sampled on the rising edge of clock.
// ----------------------------------------------------------------------------
`ifndef EVALUATION_SCORE_TEXT_PARSER_MACROS_SVH
`define EVALUATION_SCORE_TEXT_PARSER_MACROS_SVH

// Check that is switched off while reset is high.
`define ESP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that also holds across reset.
`define ESP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[sv/esp_pkg.sv]
// ----------------------------------------------------------------------------
// esp_pkg
// Types, constants and helper functions for the score text parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esp_pkg;

   localparam logic [15:0] PAWN_MAX  = 16'd2047;
   localparam logic [15:0] CENT_MAX  = 16'd99;
   localparam logic [15:0] DEPTH_MAX = 16'd255;
   localparam logic [7:0]  COUNT_MAX = 8'd255;
   localparam logic [15:0] RADIX     = 16'd10;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_BAR   = 8'h7C;

   typedef enum logic [12:0] {
      PH_IDLE  = 13'b0000000000001,
      PH_LEAD  = 13'b0000000000010,
      PH_DEPTH = 13'b0000000000100,
      PH_SIGN  = 13'b0000000001000,
      PH_PAWN1 = 13'b0000000010000,
      PH_PAWN  = 13'b0000000100000,
      PH_CENT1 = 13'b0000001000000,
      PH_CENT  = 13'b0000010000000,
      PH_BAR   = 13'b0000100000000,
      PH_BARD  = 13'b0001000000000,
      PH_SLASH = 13'b0010000000000,
      PH_TAIL  = 13'b0100000000000,
      PH_TRAIL = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  depth_acc;
      logic [10:0] pawn_acc;
      logic [6:0]  cent_acc;
      logic [7:0]  char_count;
      logic [7:0]  mark_pos;
      logic        sign_bit;
   } parse_state_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  depth;
      logic        negative;
      logic [10:0] pawns;
      logic [6:0]  centipawns;
      logic [7:0]  used;
   } result_type;

   typedef struct packed {
      logic       emit;
      result_type result;
   } step_out_type;

   // acc * 10 + digit, clamped to max; all values stay below 2^16
   function automatic logic [15:0] acc_digit(input logic [15:0] acc,
                                             input logic [7:0]  ch,
                                             input logic [15:0] max);
      logic [15:0] v;
      v = acc * RADIX + {12'd0, ch[3:0]};
      return (v > max) ? max : v;
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   function automatic logic [7:0] sat_inc(input logic [7:0] cnt);
      return (cnt < COUNT_MAX) ? cnt + 8'd1 : cnt;
   endfunction

endpackage

`default_nettype wire

[sv/evaluation_score_text_parser.sv]
// ----------------------------------------------------------------------------
// evaluation_score_text_parser
// Character-serial parser for score texts with an optional depth and suffix.
// ----------------------------------------------------------------------------
// Feed the text one character per transaction, with req_first high on the
// first character of each field; the block takes one character every cycle
// and returns a single result transaction on the character that ends the
// field (that character is not counted in used). The result appears in the
// cycle after the ending character is accepted and sits in an output
// register. While that register holds a result the response side has not
// taken, req_ready is low, whatever the next character is, so the character
// stream pauses for every cycle the response side stalls; a result drained
// in the same cycle leaves req_ready high, so fields can follow back to back.
// Characters that arrive while no field is open are dropped silently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "evaluation_score_text_parser_macros.svh"

module evaluation_score_text_parser import esp_pkg::*; (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output logic              req_ready,
   input  wire  logic [7:0]  req_ch,
   input  wire  logic        req_first,
   output logic              rsp_valid,
   input  wire  logic        rsp_ready,
   output logic              rsp_status,
   output logic [7:0]        rsp_depth,
   output logic              rsp_negative,
   output logic [10:0]       rsp_pawns,
   output logic [6:0]        rsp_centipawns,
   output logic [7:0]        rsp_used
);

   parse_state_type state_ff;
   parse_state_type state_in;
   step_out_type    step_out;
   result_type      rsp_ff;
   logic            rsp_valid_ff;
   logic            req_take;

   // Parse logic works straight off the held state and the incoming character.
   esp_step u_step (
      .ch         (req_ch),
      .first      (req_first),
      .state_now  (state_ff),
      .state_next (state_in),
      .step_out   (step_out)
   );

   // Output register frees up in the same cycle it is drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_IDLE;
         state_ff.depth_acc  <= '0;
         state_ff.pawn_acc   <= '0;
         state_ff.cent_acc   <= '0;
         state_ff.char_count <= '0;
         state_ff.mark_pos   <= '0;
         state_ff.sign_bit   <= 1'b0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take && step_out.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      if (req_take && step_out.emit) begin
         rsp_ff <= step_out.result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_depth      = rsp_ff.depth;
   assign rsp_negative   = rsp_ff.negative;
   assign rsp_pawns      = rsp_ff.pawns;
   assign rsp_centipawns = rsp_ff.centipawns;
   assign rsp_used       = rsp_ff.used;

   // Checks
   `ESP_ASSERT(a_no_take_when_full, rsp_valid_ff && !rsp_ready |-> !req_ready,
      "input taken while result stalled")
   `ESP_ASSERT(a_idle_after_emit, req_take && step_out.emit |=> state_ff.phase == PH_IDLE,
      "field still open after result")
   `ESP_ASSERT(a_error_zero, rsp_valid_ff && rsp_ff.status |-> rsp_ff.depth == 8'd0
      && rsp_ff.pawns == 11'd0 && rsp_ff.centipawns == 7'd0 && rsp_ff.used == 8'd0
      && !rsp_ff.negative, "error result with non-zero fields")
   `ESP_ASSERT(a_cent_range, state_ff.cent_acc <= CENT_MAX[6:0], "cent accumulator past saturation")
   `ESP_ASSERT_ALWAYS(a_reset_clean, reset |=> state_ff.phase == PH_IDLE && !rsp_valid_ff,
      "state not cleared by reset")

endmodule

`default_nettype wire

[sv/esp_step.sv]
// ----------------------------------------------------------------------------
// esp_step
// Next-state and result logic for one character of the score text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esp_step import esp_pkg::*; (
   input  wire  logic [7:0]      ch,
   input  wire  logic            first,
   input  wire  parse_state_type state_now,
   output parse_state_type       state_next,
   output step_out_type          step_out
);

   parse_state_type cur;
   parse_state_type nxt;
   logic            emit;
   logic            err;
   logic [7:0]      used;
   logic            dig;
   logic [15:0]     depth_fresh;
   logic [15:0]     depth_more;
   logic [15:0]     pawn_more;
   logic [15:0]     cent_more;

   always_comb begin
      cur = state_now;
      if (first) begin
         cur.phase      = PH_LEAD;
         cur.depth_acc  = '0;
         cur.pawn_acc   = '0;
         cur.cent_acc   = '0;
         cur.char_count = '0;
         cur.mark_pos   = '0;
         cur.sign_bit   = 1'b0;
      end
   end

   assign dig         = is_digit(ch);
   assign depth_fresh = acc_digit(16'd0, ch, DEPTH_MAX);
   assign depth_more  = acc_digit({8'd0, cur.depth_acc}, ch, DEPTH_MAX);
   assign pawn_more   = acc_digit({5'd0, cur.pawn_acc}, ch, PAWN_MAX);
   assign cent_more   = acc_digit({9'd0, cur.cent_acc}, ch, CENT_MAX);

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      err  = 1'b0;
      used = '0;
      case (cur.phase)
         PH_IDLE: begin
         end
         PH_LEAD, PH_SIGN: begin
            if (cur.phase == PH_LEAD && ch == CH_SPACE) begin
               nxt.char_count = sat_inc(cur.char_count);
            end else if (cur.phase == PH_LEAD && dig) begin
               nxt.depth_acc  = depth_fresh[7:0];
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = PH_DEPTH;
            end else if (ch == CH_PLUS || ch == CH_MINUS) begin
               nxt.sign_bit   = (ch == CH_MINUS);
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = PH_PAWN1;
            end else begin
               emit = 1'b1;
               err  = 1'b1;
            end
         end
         PH_DEPTH: begin
            if (dig) begin
               nxt.depth_acc  = depth_more[7:0];
               nxt.char_count = sat_inc(cur.char_count);
            end else if (ch == CH_COLON) begin
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = PH_SIGN;
            end else begin
               emit = 1'b1;
               err  = 1'b1;
            end
         end
         PH_PAWN1, PH_PAWN: begin
            if (dig) begin
               nxt.pawn_acc   = pawn_more[10:0];
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = PH_PAWN;
            end else if (cur.phase == PH_PAWN && ch == CH_DOT) begin
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = PH_CENT1;
            end else begin
               emit = 1'b1;
               err  = 1'b1;
            end
         end
         PH_CENT1, PH_CENT: begin
            if (dig) begin
               nxt.cent_acc   = cent_more[6:0];
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = PH_CENT;
            end else if (cur.phase == PH_CENT1) begin
               emit = 1'b1;
               err  = 1'b1;
            end else if (ch == CH_BAR || ch == CH_SLASH) begin
               nxt.mark_pos   = cur.char_count;
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = (ch == CH_BAR) ? PH_BAR : PH_SLASH;
            end else if (ch == CH_SPACE) begin
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = PH_TRAIL;
            end else begin
               emit = 1'b1;
               used = cur.char_count;
            end
         end
         PH_BAR, PH_BARD, PH_SLASH: begin
            if (dig) begin
               nxt.depth_acc  = depth_fresh[7:0];
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = PH_TAIL;
            end else if (cur.phase == PH_BAR && ch == CH_D) begin
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = PH_BARD;
            end else begin
               // suffix with no digit: roll the count back to the mark
               emit = 1'b1;
               used = cur.mark_pos;
            end
         end
         PH_TAIL: begin
            if (dig) begin
               nxt.depth_acc  = depth_more[7:0];
               nxt.char_count = sat_inc(cur.char_count);
            end else if (ch == CH_SPACE) begin
               nxt.char_count = sat_inc(cur.char_count);
               nxt.phase      = PH_TRAIL;
            end else begin
               emit = 1'b1;
               used = cur.char_count;
            end
         end
         PH_TRAIL: begin
            if (ch == CH_SPACE) begin
               nxt.char_count = sat_inc(cur.char_count);
            end else begin
               emit = 1'b1;
               used = cur.char_count;
            end
         end
         default: begin
            nxt.phase = PH_IDLE;
         end
      endcase
      if (emit) begin
         nxt.phase = PH_IDLE;
      end
   end

   always_comb begin
      step_out.emit = emit;
      if (err) begin
         step_out.result = '0;
         step_out.result.status = 1'b1;
      end else begin
         step_out.result.status     = 1'b0;
         step_out.result.depth      = cur.depth_acc;
         step_out.result.negative   = cur.sign_bit;
         step_out.result.pawns      = cur.pawn_acc;
         step_out.result.centipawns = cur.cent_acc;
         step_out.result.used       = used;
      end
   end

   assign state_next = nxt;

endmodule

`default_nettype wire
